// ===== rtl/core/fwlt_pkg.sv =====
// Package for the FIFO with level triggers: widths, codes, controller
// state and command types. No dependencies.
`timescale 1ns / 1ps

package fwlt_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam int OP_W      = 2;
    localparam int WORD_W    = 32;
    localparam int LEVEL_W   = 5;
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
    localparam int COND_W    = 2;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [LEVEL_W-1:0] DEPTH_RESET = LEVEL_W'(16);

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [COND_W-1:0] COND_OFF   = 2'd0;
    localparam logic [COND_W-1:0] COND_BELOW = 2'd1;
    localparam logic [COND_W-1:0] COND_EQUAL = 2'd2;
    localparam logic [COND_W-1:0] COND_ABOVE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_SENSE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_MARK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A_COND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_SENSE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B_MARK    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_B_COND    = 3'd6;

    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_ARMED = 2'd1,
        PH_FIRED = 2'd2
    } phase_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

endpackage

// ===== rtl/core/fwlt_ctrl.sv =====
// Controller for the FIFO with level triggers: transaction sequencing and
// output valid register. Depends on fwlt_pkg.
`timescale 1ns / 1ps

module fwlt_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    output fwlt_pkg::cmd_t cmd
);

    fwlt_pkg::state_t state_reg;
    fwlt_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fwlt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fwlt_pkg::ST_EXEC;
                end
            end
            fwlt_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = fwlt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fwlt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        case (state_reg)
            fwlt_pkg::ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            fwlt_pkg::ST_EXEC:
            begin
                cmd.execute = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fwlt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/fwlt_datapath.sv =====
// Datapath for the FIFO with level triggers: entry store, pointers, level,
// configuration registers, trigger phases and result register.
// Depends on fwlt_pkg.
`timescale 1ns / 1ps

module fwlt_datapath
#(
    parameter int QUEUE_DEPTH = fwlt_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = fwlt_pkg::DATA_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fwlt_pkg::cmd_t                   cmd,
    input  logic [fwlt_pkg::OP_W-1:0]        operation,
    input  logic [fwlt_pkg::WORD_W-1:0]      item_data,
    input  logic                             cfg_we,
    input  logic [fwlt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fwlt_pkg::CFG_W-1:0]       cfg_data,
    output logic                             accepted,
    output logic [fwlt_pkg::WORD_W-1:0]      out_data,
    output logic [fwlt_pkg::LEVEL_W-1:0]     level,
    output logic                             fired_a,
    output logic                             fired_b,
    output logic                             is_empty,
    output logic                             is_full
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int LW    = fwlt_pkg::LEVEL_W;
    localparam int CW    = fwlt_pkg::COND_W;
    localparam int WW    = fwlt_pkg::WORD_W;
    localparam int CAP   = (QUEUE_DEPTH < fwlt_pkg::LEVEL_MAX) ? QUEUE_DEPTH
                                                                : fwlt_pkg::LEVEL_MAX;
    localparam logic [LW-1:0]    CAP_L    = LW'(CAP);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

    localparam logic [fwlt_pkg::CFG_IDX_W-1:0] REG_SENSE [2] =
        '{fwlt_pkg::REG_A_SENSE, fwlt_pkg::REG_B_SENSE};
    localparam logic [fwlt_pkg::CFG_IDX_W-1:0] REG_MARK [2] =
        '{fwlt_pkg::REG_A_MARK, fwlt_pkg::REG_B_MARK};
    localparam logic [fwlt_pkg::CFG_IDX_W-1:0] REG_COND [2] =
        '{fwlt_pkg::REG_A_COND, fwlt_pkg::REG_B_COND};

    function automatic logic trig_test(
        input logic          sense,
        input logic [LW-1:0] mark,
        input logic [CW-1:0] cond,
        input logic [LW-1:0] cnt,
        input logic [LW-1:0] eff
    );
        logic [LW-1:0] n;
        logic          r;
        if (sense)
        begin
            n = cnt;
        end
        else
        begin
            n = (eff > cnt) ? eff - cnt : '0;
        end
        case (cond)
            fwlt_pkg::COND_BELOW: r = n < mark;
            fwlt_pkg::COND_EQUAL: r = n == mark;
            fwlt_pkg::COND_ABOVE: r = n > mark;
            default:              r = 1'b0;
        endcase
        return r;
    endfunction

    logic [DATA_WIDTH-1:0] mem [QUEUE_DEPTH];

    logic [fwlt_pkg::OP_W-1:0] op_reg;
    logic [DATA_WIDTH-1:0]     word_reg;
    logic [DATA_WIDTH-1:0]     rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [LW-1:0]    count_reg;
    logic [LW-1:0]    count_next;
    logic [LW-1:0]    max_depth_reg;
    logic [LW-1:0]    max_depth_next;

    logic                 sense_reg [2];
    logic                 sense_next [2];
    logic [LW-1:0]        mark_reg [2];
    logic [LW-1:0]        mark_next [2];
    logic [CW-1:0]        cond_reg [2];
    logic [CW-1:0]        cond_next [2];
    fwlt_pkg::phase_t     phase_reg [2];
    fwlt_pkg::phase_t     phase_next [2];
    logic                 fire [2];
    logic                 holds [2];

    logic                 accepted_reg;
    logic [WW-1:0]        out_data_reg;
    logic [LW-1:0]        level_reg;
    logic                 fired_a_reg;
    logic                 fired_b_reg;
    logic                 is_empty_reg;
    logic                 is_full_reg;

    logic [LW-1:0] eff;
    logic          enq_ok;
    logic          deq_ok;
    logic          peek_ok;
    logic          moved;

    assign eff     = (max_depth_reg > CAP_L) ? CAP_L : max_depth_reg;
    assign enq_ok  = (op_reg == fwlt_pkg::OP_ENQ) && (count_reg < eff);
    assign deq_ok  = (op_reg == fwlt_pkg::OP_DEQ) && (count_reg != '0);
    assign peek_ok = (op_reg == fwlt_pkg::OP_PEEK) && (count_reg != '0);
    assign moved   = enq_ok || deq_ok;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (enq_ok)
        begin
            tail_next  = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (deq_ok)
        begin
            head_next  = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    assign max_depth_next = (cfg_we && cfg_index == fwlt_pkg::REG_MAX_DEPTH)
                            ? cfg_data : max_depth_reg;

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            sense_next[t] = (cfg_we && cfg_index == REG_SENSE[t]) ? cfg_data[0]
                                                                 : sense_reg[t];
            mark_next[t]  = (cfg_we && cfg_index == REG_MARK[t]) ? cfg_data : mark_reg[t];
            cond_next[t]  = (cfg_we && cfg_index == REG_COND[t]) ? cfg_data[CW-1:0]
                                                                : cond_reg[t];
            phase_next[t] = phase_reg[t];
            fire[t]       = 1'b0;
            holds[t]      = 1'b0;
            if (cfg_we && cfg_index == REG_COND[t])
            begin
                holds[t] = trig_test(sense_reg[t], mark_reg[t], cfg_data[CW-1:0],
                                     count_reg, eff);
                if (cfg_data[CW-1:0] == fwlt_pkg::COND_OFF)
                begin
                    phase_next[t] = fwlt_pkg::PH_OFF;
                end
                else
                begin
                    phase_next[t] = holds[t] ? fwlt_pkg::PH_FIRED : fwlt_pkg::PH_ARMED;
                end
            end
            else if (cmd.execute && moved)
            begin
                holds[t] = trig_test(sense_reg[t], mark_reg[t], cond_reg[t],
                                     count_next, eff);
                case (phase_reg[t])
                    fwlt_pkg::PH_OFF:
                    begin
                        phase_next[t] = fwlt_pkg::PH_OFF;
                    end
                    fwlt_pkg::PH_ARMED:
                    begin
                        fire[t]       = holds[t];
                        phase_next[t] = holds[t] ? fwlt_pkg::PH_FIRED : fwlt_pkg::PH_ARMED;
                    end
                    fwlt_pkg::PH_FIRED:
                    begin
                        phase_next[t] = holds[t] ? fwlt_pkg::PH_FIRED : fwlt_pkg::PH_ARMED;
                    end
                    default:
                    begin
                        phase_next[t] = fwlt_pkg::PH_OFF;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            max_depth_reg <= fwlt_pkg::DEPTH_RESET;
            for (int t = 0; t < 2; t++)
            begin
                sense_reg[t] <= 1'b0;
                mark_reg[t]  <= '0;
                cond_reg[t]  <= fwlt_pkg::COND_OFF;
                phase_reg[t] <= fwlt_pkg::PH_OFF;
            end
        end
        else
        begin
            if (cmd.execute)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            max_depth_reg <= max_depth_next;
            for (int t = 0; t < 2; t++)
            begin
                sense_reg[t] <= sense_next[t];
                mark_reg[t]  <= mark_next[t];
                cond_reg[t]  <= cond_next[t];
                phase_reg[t] <= phase_next[t];
            end
        end
    end

    // store write at execute, head read every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.execute && enq_ok)
        begin
            mem[tail_reg] <= word_reg;
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            word_reg <= DATA_WIDTH'(item_data);
        end
        if (cmd.execute)
        begin
            accepted_reg <= moved || peek_ok;
            out_data_reg <= (deq_ok || peek_ok) ? WW'(rd_data_reg) : '0;
            level_reg    <= count_next;
            fired_a_reg  <= fire[0];
            fired_b_reg  <= fire[1];
            is_empty_reg <= (count_next == '0);
            is_full_reg  <= (count_next >= eff);
        end
    end

    assign accepted = accepted_reg;
    assign out_data = out_data_reg;
    assign level    = level_reg;
    assign fired_a  = fired_a_reg;
    assign fired_b  = fired_b_reg;
    assign is_empty = is_empty_reg;
    assign is_full  = is_full_reg;

endmodule

// ===== rtl/core/fifo_with_level_triggers.sv =====
// Top level of the FIFO with level triggers: controller plus datapath.
// Depends on fwlt_pkg, fwlt_ctrl, fwlt_datapath.
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid, in_stall | operation, item_data
//  out     | out_valid, out_stall | accepted, out_data, level, fired_a,
//          |                    |   fired_b, is_empty, is_full
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// Each transaction takes two steps: one to capture the operation while the store
// reads the head entry into its read register, one to execute and load the
// result register. The registered store read is why the steps are separate.
// No clearing pass after reset; the first transaction is taken right away.
// A stalled result holds only the execute step; a new transaction is taken
// while a result still waits on out_stall.
`timescale 1ns / 1ps

module fifo_with_level_triggers
#(
    parameter int QUEUE_DEPTH = fwlt_pkg::QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = fwlt_pkg::DATA_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [fwlt_pkg::OP_W-1:0]        operation,
    input  logic [fwlt_pkg::WORD_W-1:0]      item_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             accepted,
    output logic [fwlt_pkg::WORD_W-1:0]      out_data,
    output logic [fwlt_pkg::LEVEL_W-1:0]     level,
    output logic                             fired_a,
    output logic                             fired_b,
    output logic                             is_empty,
    output logic                             is_full,
    input  logic                             cfg_we,
    input  logic [fwlt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fwlt_pkg::CFG_W-1:0]       cfg_data
);

    fwlt_pkg::cmd_t cmd;

    fwlt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    fwlt_datapath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .operation (operation),
        .item_data (item_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accepted  (accepted),
        .out_data  (out_data),
        .level     (level),
        .fired_a   (fired_a),
        .fired_b   (fired_b),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while a transaction is in flight");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

    a_fail_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> (out_data == '0 && !fired_a && !fired_b))
        else $error("failed transaction reports data or a trigger");

    a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> out_valid)
        else $error("executed transaction did not produce a result");
`endif

endmodule
